// ===== rtl/core/reversed_word_table_search_defines.svh =====
// Assertion macros for the search RTL of the word table search.
`ifndef REVERSED_WORD_TABLE_SEARCH_DEFINES_SVH
`define REVERSED_WORD_TABLE_SEARCH_DEFINES_SVH

// Clocked assertion on clk_i, switched off while rst_ni is low.
`define RWTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: whenever the antecedent holds, the consequent holds too.
`define RWTS_ASSERT_IMP(name, ante, cons, msg) \
  `RWTS_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/rwts_pkg.sv =====
package rwts_pkg;

  // Table geometry.
  localparam int unsigned MAX_WORDS  = 1024;
  localparam int unsigned WORD_CHARS = 28;
  localparam int unsigned CHAR_DEPTH = MAX_WORDS * WORD_CHARS;
  localparam int unsigned CHAR_AW    = $clog2(CHAR_DEPTH);
  localparam int unsigned WIDX_W     = $clog2(MAX_WORDS);
  localparam int unsigned CNT_W      = $clog2(MAX_WORDS + 1);
  localparam int unsigned LEN_W      = $clog2(WORD_CHARS + 1);
  localparam int unsigned FL_W       = CNT_W + 1;

  // Fixed field widths of the stream words.
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MATCH_W = 11;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  // Write port of the character store.
  typedef struct packed {
    logic               we;
    logic [CHAR_AW-1:0] addr;
    logic [CHAR_W-1:0]  data;
  } char_wr_t;

  // Write port of the length store.
  typedef struct packed {
    logic              we;
    logic [WIDX_W-1:0] addr;
    logic [LEN_W-1:0]  data;
  } len_wr_t;

  // One search result.
  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_line;
    logic               bad_index;
  } res_t;

endpackage

// ===== rtl/core/rwts_ram.sv =====
module rwts_ram import rwts_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr_i,
  output logic [WIDTH-1:0]         rd_a_data_o,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr_i,
  output logic [WIDTH-1:0]         rd_b_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rd_a_data_o <= mem_q[rd_a_addr_i];
    rd_b_data_o <= mem_q[rd_b_addr_i];
  end

endmodule

// ===== rtl/core/rwts_loader.sv =====
module rwts_loader import rwts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              append_i,
  input  logic              clear_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              eow_i,
  output char_wr_t          char_wr_o,
  output len_wr_t           len_wr_o,
  output logic [CNT_W-1:0]  word_count_o
);

  logic [CNT_W-1:0] word_count_q, word_count_d;
  logic [LEN_W-1:0] load_len_q, load_len_d;
  logic             room;
  logic             keep_char;
  logic [LEN_W-1:0] len_next;

  // A character is kept while the table has room and the word is not full.
  assign room      = word_count_q < CNT_W'(MAX_WORDS);
  assign keep_char = room && (load_len_q < LEN_W'(WORD_CHARS));
  assign len_next  = keep_char ? load_len_q + LEN_W'(1) : load_len_q;

  // Store ports.
  always_comb begin
    char_wr_o.we   = append_i && keep_char;
    char_wr_o.addr = CHAR_AW'(CHAR_AW'(word_count_q) * CHAR_AW'(WORD_CHARS))
                     + CHAR_AW'(load_len_q);
    char_wr_o.data = char_i;
    len_wr_o.we    = append_i && eow_i && room;
    len_wr_o.addr  = WIDX_W'(word_count_q);
    len_wr_o.data  = len_next;
  end

  // Word count and length of the word being loaded.
  always_comb begin
    word_count_d = word_count_q;
    load_len_d   = load_len_q;
    priority if (clear_i) begin
      word_count_d = '0;
      load_len_d   = '0;
    end else if (append_i) begin
      load_len_d = len_next;
      if (eow_i) begin
        load_len_d = '0;
        if (room) begin
          word_count_d = word_count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
      load_len_q   <= '0;
    end else begin
      word_count_q <= word_count_d;
      load_len_q   <= load_len_d;
    end
  end

  assign word_count_o = word_count_q;

endmodule

// ===== rtl/core/rwts_search.sv =====
`include "reversed_word_table_search_defines.svh"

module rwts_search import rwts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [CNT_W-1:0]   word_count_i,
  output logic               busy_o,
  output logic [WIDX_W-1:0]  len_a_addr_o,
  input  logic [LEN_W-1:0]   len_a_data_i,
  output logic [WIDX_W-1:0]  len_b_addr_o,
  input  logic [LEN_W-1:0]   len_b_data_i,
  output logic [CHAR_AW-1:0] char_q_addr_o,
  input  logic [CHAR_W-1:0]  char_q_data_i,
  output logic [CHAR_AW-1:0] char_t_addr_o,
  input  logic [CHAR_W-1:0]  char_t_data_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_QLEN = 3'd1;
  localparam logic [2:0] S_MID  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [WIDX_W-1:0]       idx_q, idx_d;
  logic [LEN_W-1:0]        qlen_q, qlen_d;
  logic [LEN_W-1:0]        tlen_q, tlen_d;
  logic [LEN_W-1:0]        n_q, n_d;
  logic [LEN_W-1:0]        rd_i_q, rd_i_d;
  logic                    pend_q, pend_d;
  logic [CHAR_AW-1:0]      qend_q, qend_d;
  logic [CHAR_AW-1:0]      ptr_q_q, ptr_q_d;
  logic [CHAR_AW-1:0]      ptr_t_q, ptr_t_d;
  logic signed [FL_W-1:0]  first_q, first_d;
  logic signed [FL_W-1:0]  last_q, last_d;
  logic [WIDX_W-1:0]       mid_q, mid_d;
  res_t                    res_q, res_d;
  logic signed [FL_W:0]    fl_sum;
  logic [WIDX_W-1:0]       mid_calc;
  logic                    byte_ne;
  logic                    byte_gt;

  // Midpoint of the live range; the sum is never negative inside the loop.
  assign fl_sum   = (FL_W+1)'(first_q) + (FL_W+1)'(last_q);
  assign mid_calc = WIDX_W'(fl_sum >>> 1);

  assign byte_ne = char_q_data_i != char_t_data_i;
  assign byte_gt = char_q_data_i > char_t_data_i;

  // Store read addresses.
  assign len_a_addr_o  = WIDX_W'(idx_i);
  assign len_b_addr_o  = mid_calc;
  assign char_q_addr_o = ptr_q_q;
  assign char_t_addr_o = ptr_t_q;

  // Sequencer: query length, then one probe after another, one byte a cycle; a bad index goes straight to the output.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    qlen_d  = qlen_q;
    tlen_d  = tlen_q;
    n_d     = n_q;
    rd_i_d  = rd_i_q;
    pend_d  = pend_q;
    qend_d  = qend_q;
    ptr_q_d = ptr_q_q;
    ptr_t_d = ptr_t_q;
    first_d = first_q;
    last_d  = last_q;
    mid_d   = mid_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (32'(idx_i) >= 32'(word_count_i)) begin
            res_d.found      = 1'b0;
            res_d.match_line = '0;
            res_d.bad_index  = 1'b1;
            state_d          = S_OUT;
          end else begin
            idx_d   = WIDX_W'(idx_i);
            state_d = S_QLEN;
          end
        end
      end
      S_QLEN: begin
        qlen_d  = len_a_data_i;
        qend_d  = CHAR_AW'(CHAR_AW'(idx_q) * CHAR_AW'(WORD_CHARS))
                  + CHAR_AW'(len_a_data_i) - CHAR_AW'(1);
        first_d = '0;
        last_d  = FL_W'(word_count_i) - FL_W'(1);
        state_d = S_MID;
      end
      S_MID: begin
        if (first_q > last_q) begin
          res_d.found      = 1'b0;
          res_d.match_line = '0;
          res_d.bad_index  = 1'b0;
          state_d          = S_OUT;
        end else begin
          mid_d   = mid_calc;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        tlen_d  = len_b_data_i;
        n_d     = (qlen_q < len_b_data_i) ? qlen_q : len_b_data_i;
        ptr_t_d = CHAR_AW'(CHAR_AW'(mid_q) * CHAR_AW'(WORD_CHARS));
        ptr_q_d = qend_q;
        rd_i_d  = '0;
        pend_d  = 1'b0;
        state_d = S_CMP;
      end
      S_CMP: begin
        priority if (pend_q && byte_ne) begin
          // First differing byte decides.
          if (byte_gt) begin
            first_d = FL_W'(mid_q) + FL_W'(1);
          end else begin
            last_d = FL_W'(mid_q) - FL_W'(1);
          end
          state_d = S_MID;
        end else if (rd_i_q == n_q) begin
          // Common prefix equal: the shorter word is the smaller one.
          if (qlen_q > tlen_q) begin
            first_d = FL_W'(mid_q) + FL_W'(1);
            state_d = S_MID;
          end else if (qlen_q < tlen_q) begin
            last_d  = FL_W'(mid_q) - FL_W'(1);
            state_d = S_MID;
          end else begin
            res_d.found      = 1'b1;
            res_d.match_line = MATCH_W'(mid_q) + MATCH_W'(1);
            res_d.bad_index  = 1'b0;
            state_d          = S_OUT;
          end
        end else begin
          // Issue the next byte pair; the query word is read backward.
          ptr_t_d = ptr_t_q + CHAR_AW'(1);
          ptr_q_d = ptr_q_q - CHAR_AW'(1);
          rd_i_d  = rd_i_q + LEN_W'(1);
          pend_d  = 1'b1;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    qlen_q  <= qlen_d;
    tlen_q  <= tlen_d;
    n_q     <= n_d;
    rd_i_q  <= rd_i_d;
    pend_q  <= pend_d;
    qend_q  <= qend_d;
    ptr_q_q <= ptr_q_d;
    ptr_t_q <= ptr_t_d;
    first_q <= first_d;
    last_q  <= last_d;
    mid_q   <= mid_d;
    res_q   <= res_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_OUT;
  assign res_o       = res_q;

  // Checks on the sequencer.
  `RWTS_ASSERT_IMP(a_start_idle, start_i, state_q == S_IDLE,
                   "query started while a search is running")
  `RWTS_ASSERT_IMP(a_probe_range, state_q == S_LEN, CNT_W'(mid_q) < word_count_i,
                   "probe outside the stored words")
  `RWTS_ASSERT_IMP(a_byte_bound, state_q == S_CMP, rd_i_q <= n_q,
                   "byte counter ran past the common length")
  `RWTS_ASSERT_IMP(a_found_line, res_valid_o, res_o.found == (res_o.match_line != '0),
                   "found flag disagrees with the match line")
  `RWTS_ASSERT_IMP(a_bad_clean, res_valid_o && res_o.bad_index,
                   !res_o.found && (res_o.match_line == '0),
                   "bad index result carries a match")

endmodule

// ===== rtl/core/reversed_word_table_search.sv =====
// Word table with reversed-word binary search. Words stream in one byte per
// stream word (opcode append, tlast closes the word), one byte per cycle
// while no query is running, into a 28672-byte character store and a
// 1024-entry length store. A query fetches the word length, then for each
// binary-search probe fetches the probe word's length and compares one byte
// per cycle over the two read ports of the character store, until the first
// differing byte or the end of the shorter word, over at most 11 probes. A
// bad index is answered without a search. Only one query is in progress at a
// time; appends and clears are accepted while a finished result waits in the
// output register, not while the search still holds it.
module reversed_word_table_search import rwts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] char_code, [17:8] word_index, [23:18] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  input  logic        s_axis_tlast,   // end_of_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] found, [11:1] match_line, [15:12] zero
  output logic [0:0]  m_axis_tuser    // [0] bad_index
);

  opcode_e            op;
  logic               in_word;
  logic               append;
  logic               clear;
  logic               query;
  logic [CNT_W-1:0]   word_count;
  char_wr_t           char_wr;
  len_wr_t            len_wr;
  logic               busy;
  logic [WIDX_W-1:0]  len_a_addr;
  logic [LEN_W-1:0]   len_a_data;
  logic [WIDX_W-1:0]  len_b_addr;
  logic [LEN_W-1:0]   len_b_data;
  logic [CHAR_AW-1:0] char_q_addr;
  logic [CHAR_W-1:0]  char_q_data;
  logic [CHAR_AW-1:0] char_t_addr;
  logic [CHAR_W-1:0]  char_t_data;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               out_valid_q, out_valid_d;
  res_t               out_res_q;

  // Input word decode.
  assign op            = opcode_e'(s_axis_tuser);
  assign s_axis_tready = !busy;
  assign in_word       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    append = 1'b0;
    clear  = 1'b0;
    query  = 1'b0;
    unique case (op)
      OP_APPEND: append = in_word;
      OP_QUERY:  query  = in_word;
      OP_CLEAR:  clear  = in_word;
      default: begin
        append = 1'b0;
      end
    endcase
  end

  rwts_loader u_loader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .append_i     (append),
    .clear_i      (clear),
    .char_i       (s_axis_tdata[CHAR_W-1:0]),
    .eow_i        (s_axis_tlast),
    .char_wr_o    (char_wr),
    .len_wr_o     (len_wr),
    .word_count_o (word_count)
  );

  rwts_ram #(
    .DEPTH (CHAR_DEPTH),
    .WIDTH (CHAR_W)
  ) u_char_ram (
    .clk_i       (clk_i),
    .we_i        (char_wr.we),
    .wr_addr_i   (char_wr.addr),
    .wr_data_i   (char_wr.data),
    .rd_a_addr_i (char_q_addr),
    .rd_a_data_o (char_q_data),
    .rd_b_addr_i (char_t_addr),
    .rd_b_data_o (char_t_data)
  );

  rwts_ram #(
    .DEPTH (MAX_WORDS),
    .WIDTH (LEN_W)
  ) u_len_ram (
    .clk_i       (clk_i),
    .we_i        (len_wr.we),
    .wr_addr_i   (len_wr.addr),
    .wr_data_i   (len_wr.data),
    .rd_a_addr_i (len_a_addr),
    .rd_a_data_o (len_a_data),
    .rd_b_addr_i (len_b_addr),
    .rd_b_data_o (len_b_data)
  );

  rwts_search u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (query),
    .idx_i         (s_axis_tdata[CHAR_W +: IDX_W]),
    .word_count_i  (word_count),
    .busy_o        (busy),
    .len_a_addr_o  (len_a_addr),
    .len_a_data_i  (len_a_data),
    .len_b_addr_o  (len_b_addr),
    .len_b_data_i  (len_b_data),
    .char_q_addr_o (char_q_addr),
    .char_q_data_i (char_q_data),
    .char_t_addr_o (char_t_addr),
    .char_t_data_i (char_t_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_valid ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.match_line, out_res_q.found};
  assign m_axis_tuser  = out_res_q.bad_index;

endmodule
